FILE: sv/sdla_pkg.sv
// Shared types, constants and helpers for the S-box analyser core.
// Depends on nothing; every other file of the block but sdla_ram refers to it by scoped names.
`default_nettype none
package sdla_pkg;

  localparam int unsigned IN_BITS  = 4;
  localparam int unsigned OUT_BITS = 4;
  localparam int unsigned IN_SIZE  = 1 << IN_BITS;
  localparam int unsigned OUT_SIZE = 1 << OUT_BITS;
  localparam int unsigned CNT_W    = IN_BITS + 1;
  localparam int unsigned WAL_W    = IN_BITS + 2;
  localparam int unsigned DEG_W    = 3;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_ANALYZE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  typedef struct packed {
    logic                wr;
    logic [IN_BITS-1:0]  wr_addr;
    logic [OUT_BITS-1:0] wr_data;
    logic                step;
    logic [IN_BITS-1:0]  x;
    logic [IN_BITS-1:0]  a;
    logic                first;
    logic                last;
    logic                clear;
    logic                cap;
    logic                query;
    logic [OUT_BITS-1:0] col;
  } sdla_cmd_t;

  function automatic logic [DEG_W-1:0] weight(input logic [IN_BITS-1:0] v);
    logic [DEG_W-1:0] w;
    w = '0;
    for (int i = 0; i < IN_BITS; i++) begin
      w = w + DEG_W'(v[i]);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sdla_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stand-alone; holds the loaded S-box table.
`default_nettype none
module sdla_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

FILE: sv/sdla_ctrl.sv
// Controller of the S-box analyser: handshakes and sweep sequencing.
// Uses sdla_pkg for the command struct and mode codes.
`default_nettype none
module sdla_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic [sdla_pkg::IN_BITS-1:0] entry_index_i,
  input  wire logic [sdla_pkg::OUT_BITS-1:0] entry_value_i,
  input  wire logic [sdla_pkg::IN_BITS-1:0] row_sel_i,
  input  wire logic [sdla_pkg::OUT_BITS-1:0] col_sel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output sdla_pkg::sdla_cmd_t               cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_CAP   = 3'd4;

  localparam logic [sdla_pkg::IN_BITS-1:0] IdxMax = '1;

  logic [2:0]                       state_q, state_d;
  logic [sdla_pkg::IN_BITS-1:0]     a_q, a_d, x_q, x_d;
  logic                             query_q, query_d;
  logic [sdla_pkg::OUT_BITS-1:0]    col_q, col_d;
  logic                             out_vld_q, out_vld_d;
  logic                             in_acc, cap;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cap         = (state_q == S_CAP) & ~(out_vld_q & out_stall_i);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    x_d       = x_q;
    query_d   = query_q;
    col_d     = col_q;
    out_vld_d = cap | (out_vld_q & out_stall_i);
    case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i == sdla_pkg::MODE_ANALYZE) begin
          a_d     = '0;
          x_d     = '0;
          query_d = 1'b0;
          state_d = S_SWEEP;
        end else if (in_acc && mode_i == sdla_pkg::MODE_QUERY) begin
          a_d     = row_sel_i;
          x_d     = '0;
          query_d = 1'b1;
          col_d   = col_sel_i;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        x_d = x_q + 1'b1;
        if (x_q == IdxMax) begin
          if (query_q || a_q == IdxMax) begin
            state_d = S_DRAIN;
          end else begin
            a_d = a_q + 1'b1;
          end
        end
      end
      S_DRAIN: state_d = S_FOLD;
      S_FOLD:  state_d = S_CAP;
      S_CAP: begin
        if (cap) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr      = in_acc && (mode_i == sdla_pkg::MODE_LOAD);
    cmd_o.wr_addr = entry_index_i;
    cmd_o.wr_data = entry_value_i;
    cmd_o.step    = (state_q == S_SWEEP);
    cmd_o.x       = x_q;
    cmd_o.a       = a_q;
    cmd_o.first   = (x_q == '0);
    cmd_o.last    = (x_q == IdxMax);
    cmd_o.clear   = (state_q == S_SWEEP) && !query_q && (a_q == '0) && (x_q == '0);
    cmd_o.cap     = cap;
    cmd_o.query   = query_q;
    cmd_o.col     = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      a_q       <= '0;
      x_q       <= '0;
      query_q   <= 1'b0;
      col_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_q       <= a_d;
      x_q       <= x_d;
      query_q   <= query_d;
      col_q     <= col_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sdla_dp.sv
// Datapath of the S-box analyser: table RAM, per-mask lanes, row folds and result register.
// Uses sdla_pkg and instantiates sdla_ram.
`default_nettype none
module sdla_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sdla_pkg::sdla_cmd_t               cmd_i,
  output logic [sdla_pkg::CNT_W-1:0]             ddt_count_o,
  output logic signed [sdla_pkg::WAL_W-1:0]      lat_value_o,
  output logic [sdla_pkg::CNT_W-1:0]             diff_uniformity_o,
  output logic [sdla_pkg::CNT_W-1:0]             linearity_o,
  output logic [sdla_pkg::DEG_W-1:0]             min_degree_o
);

  localparam int unsigned IB = sdla_pkg::IN_BITS;
  localparam int unsigned OB = sdla_pkg::OUT_BITS;
  localparam int unsigned NL = sdla_pkg::OUT_SIZE;
  localparam int unsigned LV = OB;
  localparam int unsigned CW = sdla_pkg::CNT_W;
  localparam int unsigned WW = sdla_pkg::WAL_W;
  localparam int unsigned DW = sdla_pkg::DEG_W;

  logic [OB-1:0] s_x, s_xa;

  sdla_ram #(
    .WIDTH(OB),
    .DEPTH(sdla_pkg::IN_SIZE)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (cmd_i.wr),
    .waddr_i  (cmd_i.wr_addr),
    .wdata_i  (cmd_i.wr_data),
    .raddr_a_i(cmd_i.x),
    .raddr_b_i(cmd_i.x ^ cmd_i.a),
    .rdata_a_o(s_x),
    .rdata_b_o(s_xa)
  );

  logic          p_vld_q, p_first_q, p_last_q, rd_q;
  logic [IB-1:0] p_x_q, p_a_q, ra_q;

  logic [CW-1:0]        cnt_q  [NL];
  logic signed [WW-1:0] acc_q  [NL];
  logic                 coef_q [NL];
  logic [DW-1:0]        deg_q  [NL];
  logic [CW-1:0]        du_q, lin_q;

  logic [CW-1:0] cmax [LV+1][NL];
  logic [CW-1:0] amax [LV+1][NL];
  logic [DW-1:0] dmin [LV+1][NL];
  logic [OB-1:0] diff;
  logic          in_par, subset;
  logic [DW-1:0] row_w;

  assign diff   = s_x ^ s_xa;
  assign in_par = ^(p_a_q & p_x_q);
  assign subset = ((p_x_q & ~p_a_q) == '0);
  assign row_w  = sdla_pkg::weight(ra_q);

  // Registered lanes are folded through small max/min trees.
  always_comb begin
    for (int b = 0; b < NL; b++) begin
      cmax[0][b] = cnt_q[b];
      if (b == 0) begin
        amax[0][b] = '0;
        dmin[0][b] = '1;
      end else begin
        amax[0][b] = acc_q[b][WW-1] ? CW'(-acc_q[b]) : CW'(acc_q[b]);
        dmin[0][b] = deg_q[b];
      end
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < NL; i++) begin
        if (i < (NL >> (l + 1))) begin
          cmax[l+1][i] = (cmax[l][2*i] > cmax[l][2*i+1]) ? cmax[l][2*i] : cmax[l][2*i+1];
          amax[l+1][i] = (amax[l][2*i] > amax[l][2*i+1]) ? amax[l][2*i] : amax[l][2*i+1];
          dmin[l+1][i] = (dmin[l][2*i] < dmin[l][2*i+1]) ? dmin[l][2*i] : dmin[l][2*i+1];
        end else begin
          cmax[l+1][i] = '0;
          amax[l+1][i] = '0;
          dmin[l+1][i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.step;
      rd_q    <= p_vld_q & p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_x_q     <= cmd_i.x;
    p_a_q     <= cmd_i.a;
    p_first_q <= cmd_i.first;
    p_last_q  <= cmd_i.last;
    ra_q      <= p_a_q;
    if (p_vld_q) begin
      for (int b = 0; b < NL; b++) begin
        logic hit, sgn, f;
        hit = (diff == OB'(b));
        f   = ^(OB'(b) & s_x);
        sgn = in_par ^ f;
        cnt_q[b]  <= (p_first_q ? '0 : cnt_q[b]) + CW'(hit);
        acc_q[b]  <= (p_first_q ? '0 : acc_q[b]) + (sgn ? -WW'(1) : WW'(1));
        coef_q[b] <= (p_first_q ? 1'b0 : coef_q[b]) ^ (subset & f);
      end
    end
    if (cmd_i.clear) begin
      du_q  <= '0;
      lin_q <= '0;
      for (int b = 0; b < NL; b++) begin
        deg_q[b] <= '0;
      end
    end else if (rd_q) begin
      if (ra_q != '0 && cmax[LV][0] > du_q) begin
        du_q <= cmax[LV][0];
      end
      if (amax[LV][0] > lin_q) begin
        lin_q <= amax[LV][0];
      end
      for (int b = 0; b < NL; b++) begin
        if (coef_q[b] && row_w > deg_q[b]) begin
          deg_q[b] <= row_w;
        end
      end
    end
    if (cmd_i.cap) begin
      if (cmd_i.query) begin
        ddt_count_o       <= cnt_q[cmd_i.col];
        lat_value_o       <= acc_q[cmd_i.col];
        diff_uniformity_o <= '0;
        linearity_o       <= '0;
        min_degree_o      <= '0;
      end else begin
        ddt_count_o       <= '0;
        lat_value_o       <= '0;
        diff_uniformity_o <= du_q;
        linearity_o       <= lin_q;
        min_degree_o      <= dmin[LV][0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/sbox_differential_linear_analyzer_core.sv
// Top level of the 4-bit S-box analyser: controller plus datapath.
// Load beat: one table write. Query: 16 table reads. Analyse: 256 reads (16 rows
// of 16 entries); the two-port table RAM reads one entry pair a cycle. One item at
// a time: after a query or analysis, the next beat is taken in the cycle after the
// result is registered. Reset clears the control state only; table entries are
// undefined until loaded.
`default_nettype none
module sbox_differential_linear_analyzer_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [sdla_pkg::IN_BITS-1:0]       entry_index_i,
  input  wire logic [sdla_pkg::OUT_BITS-1:0]      entry_value_i,
  input  wire logic [sdla_pkg::IN_BITS-1:0]       row_sel_i,
  input  wire logic [sdla_pkg::OUT_BITS-1:0]      col_sel_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [sdla_pkg::CNT_W-1:0]              ddt_count_o,
  output logic signed [sdla_pkg::WAL_W-1:0]       lat_value_o,
  output logic [sdla_pkg::CNT_W-1:0]              diff_uniformity_o,
  output logic [sdla_pkg::CNT_W-1:0]              linearity_o,
  output logic [sdla_pkg::DEG_W-1:0]              min_degree_o
);

  // Depends on sdla_pkg, sdla_ctrl, sdla_dp and sdla_ram.
  // The controller walks rows (input difference / mask) and entries; the
  // datapath keeps one lane per output mask, folding each finished row into
  // running maxima and per-component degrees. The result register lets a
  // load beat be taken while a result beat is still waiting.
  sdla_pkg::sdla_cmd_t cmd;

  sdla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .row_sel_i    (row_sel_i),
    .col_sel_i    (col_sel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd)
  );

  sdla_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .ddt_count_o      (ddt_count_o),
    .lat_value_o      (lat_value_o),
    .diff_uniformity_o(diff_uniformity_o),
    .linearity_o      (linearity_o),
    .min_degree_o     (min_degree_o)
  );

endmodule
`default_nettype wire

FILE: sv/sdla_checker.sv
// Port-level checks for the S-box analyser core, bound to the top level.
// Depends on sdla_pkg for mode codes.
`default_nettype none
module sdla_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [4:0] ddt_count_o,
  input wire logic [5:0] lat_value_o,
  input wire logic [4:0] diff_uniformity_o,
  input wire logic [4:0] linearity_o,
  input wire logic [2:0] min_degree_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (mode_i == sdla_pkg::MODE_ANALYZE || mode_i == sdla_pkg::MODE_QUERY) |=> in_stall_o)
    else $error("core not busy after analyse or query beat");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ddt_count_o == 5'd0 && lat_value_o == 6'd0) ||
                    (diff_uniformity_o == 5'd0 && linearity_o == 5'd0 && min_degree_o == 3'd0))
    else $error("result mixes query and analyse fields");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ddt_count_o <= 5'd16 && min_degree_o <= 3'd4 && linearity_o <= 5'd16)
    else $error("result field out of range");

endmodule

bind sbox_differential_linear_analyzer_core sdla_checker u_sdla_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .mode_i           (mode_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .ddt_count_o      (ddt_count_o),
  .lat_value_o      (lat_value_o),
  .diff_uniformity_o(diff_uniformity_o),
  .linearity_o      (linearity_o),
  .min_degree_o     (min_degree_o)
);
`default_nettype wire

FILE: tb/sv/tb_sbox_differential_linear_analyzer_core.sv
// Self-checking testbench for the S-box analyser core: random bursts of loads,
// queries and analyses are checked against an in-bench predictor by a scoreboard.
// Depends on sdla_pkg and sbox_differential_linear_analyzer_core.
`default_nettype none
module tb_sbox_differential_linear_analyzer_core;

  localparam int unsigned IN_BITS  = sdla_pkg::IN_BITS;
  localparam int unsigned OUT_BITS = sdla_pkg::OUT_BITS;
  localparam int unsigned IN_SIZE  = sdla_pkg::IN_SIZE;
  localparam int unsigned OUT_SIZE = sdla_pkg::OUT_SIZE;
  localparam int unsigned CNT_W    = sdla_pkg::CNT_W;
  localparam int unsigned WAL_W    = sdla_pkg::WAL_W;
  localparam int unsigned DEG_W    = sdla_pkg::DEG_W;
  localparam logic [1:0] MODE_LOAD    = sdla_pkg::MODE_LOAD;
  localparam logic [1:0] MODE_ANALYZE = sdla_pkg::MODE_ANALYZE;
  localparam logic [1:0] MODE_QUERY   = sdla_pkg::MODE_QUERY;

  // Mode 3 carries no meaning; the core must ignore it.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 850;

  typedef struct packed {
    logic [CNT_W-1:0]        ddt;
    logic signed [WAL_W-1:0] lat;
    logic [CNT_W-1:0]        du;
    logic [CNT_W-1:0]        lin;
    logic [DEG_W-1:0]        deg;
  } sbox_result_t;

  // Scoreboard: keeps its own copy of the S-box, predicts each result beat and
  // compares the beats that leave the core in order.
  class sbox_scoreboard;
    logic [OUT_BITS-1:0] sbox_copy [IN_SIZE];
    sbox_result_t        awaited [$];
    int unsigned         mismatches;

    function int unsigned diff_count(logic [IN_BITS-1:0] a, logic [OUT_BITS-1:0] b);
      int unsigned cnt;
      cnt = 0;
      for (int x = 0; x < IN_SIZE; x++) begin
        if ((sbox_copy[x] ^ sbox_copy[x ^ a]) == b) cnt++;
      end
      return cnt;
    endfunction

    function int walsh_sum(logic [IN_BITS-1:0] a, logic [OUT_BITS-1:0] b);
      int s;
      logic [IN_BITS-1:0] xv;
      s = 0;
      for (int x = 0; x < IN_SIZE; x++) begin
        xv = IN_BITS'(x);
        if (^((a & xv) ^ (b & sbox_copy[x]))) s = s - 1;
        else s = s + 1;
      end
      return s;
    endfunction

    // Algebraic degree of the component b.S(x), via the Moebius transform.
    function int unsigned component_degree(logic [OUT_BITS-1:0] b);
      logic anf [IN_SIZE];
      int unsigned d;
      d = 0;
      for (int x = 0; x < IN_SIZE; x++) anf[x] = ^(b & sbox_copy[x]);
      for (int h = 1; h < IN_SIZE; h = h << 1) begin
        for (int i = 0; i < IN_SIZE; i += 2 * h) begin
          for (int j = i; j < i + h; j++) anf[j + h] = anf[j + h] ^ anf[j];
        end
      end
      for (int x = 0; x < IN_SIZE; x++) begin
        if (anf[x] && $countones(x) > d) d = $countones(x);
      end
      return d;
    endfunction

    function void note_input(logic [1:0] mode, logic [IN_BITS-1:0] idx,
                             logic [OUT_BITS-1:0] val, logic [IN_BITS-1:0] row,
                             logic [OUT_BITS-1:0] col);
      sbox_result_t r;
      int w;
      int unsigned du, lin, mag, d, mindeg;
      r = '0;
      if (mode == MODE_LOAD) begin
        sbox_copy[idx] = val;
      end else if (mode == MODE_ANALYZE) begin
        du = 0;
        lin = 0;
        mindeg = 0;
        for (int a = 1; a < IN_SIZE; a++) begin
          for (int b = 0; b < OUT_SIZE; b++) begin
            if (diff_count(IN_BITS'(a), OUT_BITS'(b)) > du)
              du = diff_count(IN_BITS'(a), OUT_BITS'(b));
          end
        end
        for (int a = 0; a < IN_SIZE; a++) begin
          for (int b = 1; b < OUT_SIZE; b++) begin
            w = walsh_sum(IN_BITS'(a), OUT_BITS'(b));
            mag = (w < 0) ? -w : w;
            if (mag > lin) lin = mag;
          end
        end
        for (int b = 1; b < OUT_SIZE; b++) begin
          d = component_degree(OUT_BITS'(b));
          if (b == 1 || d < mindeg) mindeg = d;
        end
        r.du = CNT_W'(du);
        r.lin = CNT_W'(lin);
        r.deg = DEG_W'(mindeg);
        awaited.push_back(r);
      end else if (mode == MODE_QUERY) begin
        r.ddt = CNT_W'(diff_count(row, col));
        r.lat = WAL_W'(walsh_sum(row, col));
        awaited.push_back(r);
      end
    endfunction

    task report(string what, int got, int exp);
      $display("mismatch on %s: got %0d, expected %0d", what, got, exp);
      mismatches++;
    endtask

    task check_result(sbox_result_t got);
      sbox_result_t exp;
      if (awaited.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        exp = awaited.pop_front();
        if (got.ddt !== exp.ddt) report("ddt_count", got.ddt, exp.ddt);
        if (got.lat !== exp.lat) report("lat_value", got.lat, exp.lat);
        if (got.du !== exp.du) report("diff_uniformity", got.du, exp.du);
        if (got.lin !== exp.lin) report("linearity", got.lin, exp.lin);
        if (got.deg !== exp.deg) report("min_degree", got.deg, exp.deg);
      end
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  mode_i = MODE_NONE;
  logic [IN_BITS-1:0]          entry_index_i = '0;
  logic [OUT_BITS-1:0]         entry_value_i = '0;
  logic [IN_BITS-1:0]          row_sel_i = '0;
  logic [OUT_BITS-1:0]         col_sel_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [CNT_W-1:0]            ddt_count_o;
  logic signed [WAL_W-1:0]     lat_value_o;
  logic [CNT_W-1:0]            diff_uniformity_o;
  logic [CNT_W-1:0]            linearity_o;
  logic [DEG_W-1:0]            min_degree_o;

  sbox_scoreboard sb = new();
  int unsigned cycle_count = 0;
  logic [OUT_BITS-1:0] present_sbox [IN_SIZE] = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0,
      4'hA, 4'hD, 4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};

  sbox_differential_linear_analyzer_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Every driven signal changes only just after a rising edge, so the values
  // seen at the falling edge are exactly those that the next rising edge samples.
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_input(mode_i, entry_index_i, entry_value_i, row_sel_i, col_sel_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{ddt_count_o, lat_value_o, diff_uniformity_o, linearity_o,
                        min_degree_o});
  end

  // Watchdog: a hung core must not keep the run going for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: switches between random stall styles, and once holds off for a
  // long stretch so that the core fills up and has to stall the sender.
  initial begin
    int unsigned rcyc;
    int unsigned style;
    rcyc = 0;
    style = 0;
    forever begin
      @(posedge clk_i);
      rcyc++;
      if (rcyc % 64 == 0) style = $urandom_range(0, 3);
      if (rcyc >= 4000 && rcyc < 4800) out_stall_i <= 1'b1;
      else if (style == 0) out_stall_i <= 1'b0;
      else if (style == 1) out_stall_i <= ($urandom_range(0, 1) == 1);
      else if (style == 2) out_stall_i <= ($urandom_range(0, 7) == 0);
      else out_stall_i <= ((rcyc / 5) % 2 == 1);
    end
  end

  // One input beat: present it, then hold it steady until the core takes it.
  task send_beat(logic [1:0] mode, logic [IN_BITS-1:0] idx, logic [OUT_BITS-1:0] val,
                 logic [IN_BITS-1:0] row, logic [OUT_BITS-1:0] col);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    entry_index_i <= idx;
    entry_value_i <= val;
    row_sel_i <= row;
    col_sel_i <= col;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task idle_gap(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random content everywhere the mode does not care, so that every input bit toggles.
  task send_random(logic [1:0] mode);
    send_beat(mode, IN_BITS'($urandom), OUT_BITS'($urandom), IN_BITS'($urandom),
              OUT_BITS'($urandom));
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    int unsigned perm [IN_SIZE];
    int unsigned tmp, k;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a full table with both value extremes, then analysis,
    // the trivial cell, the all-ones cell, an empty cell, a further cell and an ignored mode.
    for (int i = 0; i < IN_SIZE; i++)
      send_beat(MODE_LOAD, IN_BITS'(i), present_sbox[i], '0, '0);
    send_beat(MODE_ANALYZE, '0, '0, '0, '0);
    send_beat(MODE_QUERY, '0, '0, '0, '0);
    send_beat(MODE_QUERY, '1, '1, '1, '1);
    send_beat(MODE_QUERY, '0, '0, '0, 4'h5);
    send_beat(MODE_QUERY, '1, '1, 4'h8, 4'h3);
    send_beat(MODE_NONE, '1, '1, '1, '1);

    // Random part: bursts of beats with gaps. Most beats query cells; others load
    // entries, analyse, or reload the table (often as a permutation) and analyse it.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int n = 0; n < burst; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          for (int i = 0; i < IN_SIZE; i++) perm[i] = i;
          for (int i = IN_SIZE - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
          end
          pick = $urandom_range(0, 3);
          for (int i = 0; i < IN_SIZE; i++) begin
            if (pick == 0) send_beat(MODE_LOAD, IN_BITS'(i), OUT_BITS'($urandom), '0, '0);
            else if (pick == 1) send_beat(MODE_LOAD, IN_BITS'(i), OUT_BITS'(i & 1), '0, '0);
            else send_beat(MODE_LOAD, IN_BITS'(i), OUT_BITS'(perm[i]), '0, '0);
          end
          send_random(MODE_ANALYZE);
          sent += IN_SIZE + 1;
        end else if (pick < 30) begin
          send_random(MODE_LOAD);
          sent++;
        end else if (pick < 40) begin
          send_random(MODE_ANALYZE);
          sent++;
        end else if (pick < 95) begin
          send_random(MODE_QUERY);
          sent++;
        end else begin
          send_random(MODE_NONE);
        end
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
    end
    in_valid_i <= 1'b0;

    // Drain: every predicted beat must arrive, then allow the core to settle.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
